@@ src/idr_pkg.sv @@
package idr_pkg;

    localparam int unsigned W_Q   = 32;
    localparam int unsigned W_OP  = 34;
    localparam int unsigned W_P   = 68;
    localparam int unsigned W_ANG = 35;
    localparam int unsigned W_RED = 46;

    localparam logic [W_RED-1:0]         L_TWO_PI_RED = 46'd6746518852;
    localparam logic signed [W_ANG-1:0]  L_TWO_PI     = 35'sd6746518852;
    localparam logic signed [W_ANG-1:0]  L_PI         = 35'sd3373259426;
    localparam logic signed [W_ANG-1:0]  L_HALF_PI    = 35'sd1686629713;
    localparam logic signed [W_OP-1:0]   L_Q30_ONE    = 34'sd1073741824;
    localparam logic signed [W_OP-1:0]   L_GAIN       = 34'sd652032874;
    localparam logic signed [W_P-1:0]    L_SAT_MAX    = 68'sd2147483647;
    localparam logic signed [W_P-1:0]    L_SAT_MIN    = -68'sd2147483648;

    // matrix sequencer: operand sources
    localparam logic [2:0] SRC_SX = 3'd0;
    localparam logic [2:0] SRC_CX = 3'd1;
    localparam logic [2:0] SRC_SY = 3'd2;
    localparam logic [2:0] SRC_CY = 3'd3;
    localparam logic [2:0] SRC_SZ = 3'd4;
    localparam logic [2:0] SRC_CZ = 3'd5;
    localparam logic [2:0] SRC_T0 = 3'd6;
    localparam logic [2:0] SRC_T1 = 3'd7;

    // destinations 0..8 are matrix entries in row order
    localparam logic [3:0] DST_M00 = 4'd0;
    localparam logic [3:0] DST_M01 = 4'd1;
    localparam logic [3:0] DST_M02 = 4'd2;
    localparam logic [3:0] DST_M10 = 4'd3;
    localparam logic [3:0] DST_M11 = 4'd4;
    localparam logic [3:0] DST_M12 = 4'd5;
    localparam logic [3:0] DST_M20 = 4'd6;
    localparam logic [3:0] DST_M21 = 4'd7;
    localparam logic [3:0] DST_M22 = 4'd8;
    localparam logic [3:0] DST_T0  = 4'd9;
    localparam logic [3:0] DST_T1  = 4'd10;

    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_NEG = 2'd1;
    localparam logic [1:0] MODE_ADD = 2'd2;

    localparam logic [3:0] MAT_LAST = 4'd13;

    typedef struct packed {
        logic [2:0] src_a;
        logic [2:0] src_b;
        logic [3:0] dst;
        logic [1:0] mode;
    } t_mat_op;

    typedef struct packed {
        logic                   done;
        logic                   flip;
        logic signed [W_OP-1:0] x;
        logic signed [W_OP-1:0] y;
    } t_trig_res;

    function automatic t_mat_op f_mat_op(input logic [3:0] k);
        t_mat_op op;
        case (k)
            4'd0:    op = '{SRC_SX, SRC_SY, DST_T0,  MODE_SET};
            4'd1:    op = '{SRC_CX, SRC_SY, DST_T1,  MODE_SET};
            4'd2:    op = '{SRC_CY, SRC_CZ, DST_M00, MODE_SET};
            4'd3:    op = '{SRC_CX, SRC_SZ, DST_M01, MODE_NEG};
            4'd4:    op = '{SRC_T0, SRC_CZ, DST_M01, MODE_ADD};
            4'd5:    op = '{SRC_SX, SRC_SZ, DST_M02, MODE_SET};
            4'd6:    op = '{SRC_T1, SRC_CZ, DST_M02, MODE_ADD};
            4'd7:    op = '{SRC_CY, SRC_SZ, DST_M10, MODE_SET};
            4'd8:    op = '{SRC_CX, SRC_CZ, DST_M11, MODE_SET};
            4'd9:    op = '{SRC_T0, SRC_SZ, DST_M11, MODE_ADD};
            4'd10:   op = '{SRC_SX, SRC_CZ, DST_M12, MODE_NEG};
            4'd11:   op = '{SRC_T1, SRC_SZ, DST_M12, MODE_ADD};
            4'd12:   op = '{SRC_SX, SRC_CY, DST_M21, MODE_SET};
            4'd13:   op = '{SRC_CX, SRC_CY, DST_M22, MODE_SET};
            default: op = '{SRC_SX, SRC_SX, DST_T0,  MODE_SET};
        endcase
        return op;
    endfunction

    function automatic logic signed [W_ANG-1:0] f_atan(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            5'd24:   v = 31'd63;
            5'd25:   v = 31'd31;
            5'd26:   v = 31'd15;
            5'd27:   v = 31'd7;
            5'd28:   v = 31'd3;
            5'd29:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return signed'({4'd0, v});
    endfunction

    function automatic logic signed [W_Q-1:0] f_sat32(input logic signed [W_P-1:0] v);
        logic signed [W_Q-1:0] r;
        if (v > L_SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < L_SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[W_Q-1:0];
        end
        return r;
    endfunction

    // round half up, then shift right 16, back to 68 bits
    function automatic logic signed [W_P-1:0] f_rnd16(input logic signed [W_P-1:0] v);
        logic signed [W_P-1:0] t;
        t = v + 68'sd32768;
        return {{16{t[W_P-1]}}, t[W_P-1:16]};
    endfunction

    function automatic logic signed [W_P-1:0] f_rnd30(input logic signed [W_P-1:0] v);
        logic signed [W_P-1:0] t;
        t = v + 68'sd536870912;
        return {{30{t[W_P-1]}}, t[W_P-1:30]};
    endfunction

endpackage

@@ src/imu_dead_reckoning_step_core.sv @@
// Strapdown dead reckoning, one IMU sample per request. Velocity, attitude and
// position are Q16.16 and are updated in turn: velocity by accel*dt, attitude by
// rate*dt rotated through a Z-Y-X matrix built from the current angles, and
// position by velocity*dt rotated by the new angles; all sums saturate. One
// 34x34 multiplier and one CORDIC unit are shared under a sequencer. The
// attitude rotation is skipped when all rate increments are zero and the
// position rotation when all angles are zero; when one runs, the CORDIC
// iterations take most of a request's time. The request stall stays high
// until the result is taken. A write to a start register loads that
// position coordinate at once.
module imu_dead_reckoning_step_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic signed [31:0] i_rate_z,
    input  logic [15:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_roll,
    output logic signed [31:0] o_pitch,
    output logic signed [31:0] o_yaw,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_out_rate_x,
    output logic signed [31:0] o_out_rate_y,
    output logic signed [31:0] o_out_rate_z
);
    import idr_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_VEL_M   = 5'd1;
    localparam logic [4:0] S_VEL_W   = 5'd2;
    localparam logic [4:0] S_DT_M    = 5'd3;
    localparam logic [4:0] S_DT_W    = 5'd4;
    localparam logic [4:0] S_CHK     = 5'd5;
    localparam logic [4:0] S_TRIG_GO = 5'd6;
    localparam logic [4:0] S_TRIG_WT = 5'd7;
    localparam logic [4:0] S_GAIN_C  = 5'd8;
    localparam logic [4:0] S_GAIN_S  = 5'd9;
    localparam logic [4:0] S_GAIN_W  = 5'd10;
    localparam logic [4:0] S_MAT_M   = 5'd11;
    localparam logic [4:0] S_MAT_W   = 5'd12;
    localparam logic [4:0] S_ROT_M   = 5'd13;
    localparam logic [4:0] S_ROT_W   = 5'd14;
    localparam logic [4:0] S_ROT_CP  = 5'd15;
    localparam logic [4:0] S_ADD     = 5'd16;
    localparam logic [4:0] S_OUT     = 5'd17;

    logic [4:0] r_state;
    logic [1:0] r_i;
    logic [1:0] r_c;
    logic [3:0] r_k;
    logic       r_ph;

    logic signed [W_Q-1:0]  r_pos  [3];
    logic signed [W_Q-1:0]  r_vel  [3];
    logic signed [W_Q-1:0]  r_att  [3];
    logic signed [W_Q-1:0]  r_rate [3];
    logic signed [W_Q-1:0]  r_acc  [3];
    logic signed [W_Q-1:0]  r_inc  [3];
    logic signed [W_Q-1:0]  r_rot  [3];
    logic signed [W_OP-1:0] r_sn   [3];
    logic signed [W_OP-1:0] r_cs   [3];
    logic signed [W_OP-1:0] r_m    [9];
    logic signed [W_OP-1:0] r_t0;
    logic signed [W_OP-1:0] r_t1;
    logic signed [W_P-1:0]  r_sum;
    logic [15:0]            r_dt;

    logic                   w_mul_en;
    logic signed [W_OP-1:0] w_mul_a;
    logic signed [W_OP-1:0] w_mul_b;
    logic signed [W_P-1:0]  w_p;
    t_trig_res              w_trig;
    logic                   w_trig_go;
    t_mat_op                w_op;
    logic [3:0]             w_midx;
    logic signed [W_Q-1:0]  w_dtv;
    logic signed [W_OP-1:0] w_r30;
    logic signed [W_P-1:0]  w_acc_sum;
    logic                   w_any;

    function automatic logic signed [W_OP-1:0] f_ext(input logic signed [W_Q-1:0] v);
        return {{(W_OP-W_Q){v[W_Q-1]}}, v};
    endfunction

    function automatic logic signed [W_P-1:0] f_ext_p(input logic signed [W_Q-1:0] v);
        return {{(W_P-W_Q){v[W_Q-1]}}, v};
    endfunction

    idr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    idr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_trig_go),
        .i_angle (r_att[r_i]),
        .o_res   (w_trig)
    );

    function automatic logic signed [W_OP-1:0] f_src(
        input logic [2:0] s,
        input logic signed [W_OP-1:0] sx, cx, sy, cy, sz, cz, t0, t1
    );
        logic signed [W_OP-1:0] v;
        case (s)
            SRC_SX:  v = sx;
            SRC_CX:  v = cx;
            SRC_SY:  v = sy;
            SRC_CY:  v = cy;
            SRC_SZ:  v = sz;
            SRC_CZ:  v = cz;
            SRC_T0:  v = t0;
            SRC_T1:  v = t1;
            default: v = t1;
        endcase
        return v;
    endfunction

    always_comb begin
        w_op      = f_mat_op(r_k);
        w_midx    = 4'({2'd0, r_i} * 4'd3) + {2'd0, r_c};
        w_dtv     = f_sat32(f_rnd16(w_p));
        w_r30     = W_OP'(f_rnd30(w_p));
        w_acc_sum = ((r_c == 2'd0) ? '0 : r_sum) + w_p;
        w_trig_go = (r_state == S_TRIG_GO);
        if (r_ph) begin
            w_any = (r_att[0] != '0) || (r_att[1] != '0) || (r_att[2] != '0);
        end else begin
            w_any = (r_inc[0] != '0) || (r_inc[1] != '0) || (r_inc[2] != '0);
        end
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_VEL_M: begin
                w_mul_a = f_ext(r_acc[r_i]);
                w_mul_b = {{(W_OP-16){1'b0}}, r_dt};
            end
            S_DT_M: begin
                w_mul_a = r_ph ? f_ext(r_vel[r_i]) : f_ext(r_rate[r_i]);
                w_mul_b = {{(W_OP-16){1'b0}}, r_dt};
            end
            S_GAIN_C: begin
                w_mul_a = w_trig.x;
                w_mul_b = L_GAIN;
            end
            S_GAIN_S: begin
                w_mul_a = w_trig.y;
                w_mul_b = L_GAIN;
            end
            S_MAT_M: begin
                w_mul_a = f_src(w_op.src_a, r_sn[0], r_cs[0], r_sn[1], r_cs[1],
                                r_sn[2], r_cs[2], r_t0, r_t1);
                w_mul_b = f_src(w_op.src_b, r_sn[0], r_cs[0], r_sn[1], r_cs[1],
                                r_sn[2], r_cs[2], r_t0, r_t1);
            end
            S_ROT_M: begin
                w_mul_a = r_m[w_midx];
                w_mul_b = f_ext(r_inc[r_c]);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_c     <= '0;
            r_k     <= '0;
            r_ph    <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_pos[j]  <= '0;
                r_vel[j]  <= '0;
                r_att[j]  <= '0;
                r_rate[j] <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_idx != 2'd3)) begin
                r_pos[i_cfg_idx] <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_acc[0]  <= i_accel_x;
                        r_acc[1]  <= i_accel_y;
                        r_acc[2]  <= i_accel_z;
                        r_rate[0] <= i_rate_x;
                        r_rate[1] <= i_rate_y;
                        r_rate[2] <= i_rate_z;
                        r_dt      <= i_time_step;
                        r_i       <= '0;
                        r_ph      <= 1'b0;
                        r_state   <= S_VEL_M;
                    end
                end
                S_VEL_M: r_state <= S_VEL_W;
                S_VEL_W: begin
                    r_vel[r_i] <= f_sat32(f_ext_p(r_vel[r_i]) + f_ext_p(w_dtv));
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= S_DT_M;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_VEL_M;
                    end
                end
                S_DT_M: r_state <= S_DT_W;
                S_DT_W: begin
                    r_inc[r_i] <= w_dtv;
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DT_M;
                    end
                end
                S_CHK: r_state <= w_any ? S_TRIG_GO : S_ADD;
                S_TRIG_GO: r_state <= S_TRIG_WT;
                S_TRIG_WT: begin
                    if (w_trig.done) begin
                        r_state <= S_GAIN_C;
                    end
                end
                S_GAIN_C: r_state <= S_GAIN_S;
                S_GAIN_S: begin
                    r_cs[r_i] <= w_trig.flip ? -w_r30 : w_r30;
                    r_state   <= S_GAIN_W;
                end
                S_GAIN_W: begin
                    r_sn[r_i] <= w_trig.flip ? -w_r30 : w_r30;
                    if (r_i == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_MAT_M;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_TRIG_GO;
                    end
                end
                S_MAT_M: r_state <= S_MAT_W;
                S_MAT_W: begin
                    if (w_op.dst == DST_T0) begin
                        r_t0 <= w_r30;
                    end else if (w_op.dst == DST_T1) begin
                        r_t1 <= w_r30;
                    end else if (w_op.dst <= DST_M22) begin
                        case (w_op.mode)
                            MODE_NEG: r_m[w_op.dst] <= -w_r30;
                            MODE_ADD: r_m[w_op.dst] <= r_m[w_op.dst] + w_r30;
                            default:  r_m[w_op.dst] <= w_r30;
                        endcase
                    end
                    if (r_k == MAT_LAST) begin
                        r_m[DST_M20] <= -r_sn[1];
                        r_i          <= '0;
                        r_c          <= '0;
                        r_state      <= S_ROT_M;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_MAT_M;
                    end
                end
                S_ROT_M: r_state <= S_ROT_W;
                S_ROT_W: begin
                    r_sum <= w_acc_sum;
                    if (r_c == 2'd2) begin
                        r_rot[r_i] <= f_sat32(f_rnd30(w_acc_sum));
                        r_c        <= '0;
                        if (r_i == 2'd2) begin
                            r_state <= S_ROT_CP;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= S_ROT_M;
                        end
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_ROT_M;
                    end
                end
                S_ROT_CP: begin
                    for (int j = 0; j < 3; j++) begin
                        r_inc[j] <= r_rot[j];
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int j = 0; j < 3; j++) begin
                        if (r_ph) begin
                            r_pos[j] <= f_sat32(f_ext_p(r_pos[j]) + f_ext_p(r_inc[j]));
                        end else begin
                            r_att[j] <= f_sat32(f_ext_p(r_att[j]) + f_ext_p(r_inc[j]));
                        end
                    end
                    r_i <= '0;
                    if (r_ph) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ph    <= 1'b1;
                        r_state <= S_DT_M;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_pos_x      = r_pos[0];
    assign o_pos_y      = r_pos[1];
    assign o_pos_z      = r_pos[2];
    assign o_roll       = r_att[0];
    assign o_pitch      = r_att[1];
    assign o_yaw        = r_att[2];
    assign o_vel_x      = r_vel[0];
    assign o_vel_y      = r_vel[1];
    assign o_vel_z      = r_vel[2];
    assign o_out_rate_x = r_rate[0];
    assign o_out_rate_y = r_rate[1];
    assign o_out_rate_z = r_rate[2];

`ifndef NO_ASSERTIONS
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while result pending");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state == S_VEL_M)
        else $error("accepted request did not start");
    a_trig_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trig.done |-> r_state == S_TRIG_WT)
        else $error("trig result outside wait");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i != 2'd3) && (r_c != 2'd3))
        else $error("index out of range");
`endif

endmodule

@@ src/idr_mul.sv @@
module idr_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [idr_pkg::W_OP-1:0]     i_a,
    input  logic signed [idr_pkg::W_OP-1:0]     i_b,
    output logic signed [idr_pkg::W_P-1:0]      o_p
);
    import idr_pkg::*;

    logic signed [W_P-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

@@ src/idr_cordic.sv @@
module idr_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [idr_pkg::W_Q-1:0]  i_angle,
    output idr_pkg::t_trig_res              o_res
);
    import idr_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam logic [4:0] IT_LAST = 5'(NSTEP - 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RED  = 2'd1;
    localparam logic [1:0] C_FOLD = 2'd2;
    localparam logic [1:0] C_ITER = 2'd3;

    logic [1:0]              r_state;
    logic [3:0]              r_k;
    logic [4:0]              r_it;
    logic [W_RED-1:0]        r_rem;
    logic                    r_neg;
    logic                    r_flip;
    logic                    r_done;
    logic signed [W_ANG-1:0] r_z;
    logic signed [W_OP-1:0]  r_x;
    logic signed [W_OP-1:0]  r_y;

    logic signed [W_RED-1:0] w_scaled;
    logic [W_RED-1:0]        w_mag;
    logic [W_RED-1:0]        w_sub;
    logic signed [W_ANG-1:0] w_base;
    logic signed [W_ANG-1:0] w_wrap;
    logic signed [W_OP-1:0]  w_dx;
    logic signed [W_OP-1:0]  w_dy;

    always_comb begin
        w_scaled = {i_angle, 14'd0};
        w_mag    = i_angle[W_Q-1] ? W_RED'(-w_scaled) : W_RED'(w_scaled);
        w_sub    = L_TWO_PI_RED << r_k;
        // truncating modulo of a negative angle wraps back into [0, 2pi)
        if (r_neg && (r_rem != '0)) begin
            w_base = L_TWO_PI - signed'(r_rem[W_ANG-1:0]);
        end else begin
            w_base = signed'(r_rem[W_ANG-1:0]);
        end
        w_wrap = (w_base > L_PI) ? (w_base - L_TWO_PI) : w_base;
        w_dx   = r_y >>> r_it;
        w_dy   = r_x >>> r_it;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_it    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_rem   <= w_mag;
                        r_neg   <= i_angle[W_Q-1];
                        r_k     <= 4'd12;
                        r_state <= C_RED;
                    end
                end
                C_RED: begin
                    if (r_rem >= w_sub) begin
                        r_rem <= r_rem - w_sub;
                    end
                    if (r_k == 4'd0) begin
                        r_state <= C_FOLD;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                C_FOLD: begin
                    if (w_wrap > L_HALF_PI) begin
                        r_z    <= w_wrap - L_PI;
                        r_flip <= 1'b1;
                    end else if (w_wrap < -L_HALF_PI) begin
                        r_z    <= w_wrap + L_PI;
                        r_flip <= 1'b1;
                    end else begin
                        r_z    <= w_wrap;
                        r_flip <= 1'b0;
                    end
                    r_x     <= L_Q30_ONE;
                    r_y     <= '0;
                    r_it    <= '0;
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - f_atan(r_it);
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + f_atan(r_it);
                    end
                    if (r_it == IT_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_it <= r_it + 5'd1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.flip = r_flip;
    assign o_res.x    = r_x;
    assign o_res.y    = r_y;

`ifndef NO_ASSERTIONS
    a_done_from_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == C_ITER)
        else $error("cordic done without iteration");
    a_red_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_RED && r_k == 4'd0) |=> r_state == C_FOLD)
        else $error("reduction did not end in fold");
    a_fold_to_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_FOLD |=> (r_state == C_ITER && r_it == 5'd0))
        else $error("fold did not start iterations");
`endif

endmodule

@@ tb/imu_dead_reckoning_step_checker.sv @@
module imu_dead_reckoning_step_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic signed [31:0] i_rate_z,
    input  logic [15:0]        i_time_step,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [11:0][31:0]  i_result,
    output int                 o_errors,
    output int                 o_pending
);

    typedef logic signed [69:0] t_wide;
    typedef logic signed [31:0] t_q16;

    localparam int TRIG_STEPS = 16;
    localparam t_wide TWO_PI = 70'sd6746518852;
    localparam t_wide PI_Q30 = 70'sd3373259426;
    localparam t_wide HALF_PI = 70'sd1686629713;
    localparam t_wide GAIN_Q30 = 70'sd652032874;
    localparam int NUM_REGS = 3;

    localparam longint ARCTAN_Q30 [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1
    };

    string field_names [12] = '{"pos_x", "pos_y", "pos_z", "roll", "pitch", "yaw",
        "vel_x", "vel_y", "vel_z", "out_rate_x", "out_rate_y", "out_rate_z"};

    t_q16 position [3];
    t_q16 velocity [3];
    t_q16 attitude [3];
    t_q16 body_rates [3];
    logic [11:0][31:0] state_q [$];
    int errors = 0;

    function automatic t_wide round_shr(t_wide x, int s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    function automatic t_q16 clamp32(t_wide x);
        if (x > 70'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -70'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic t_wide q30_mul(t_wide a, t_wide b);
        return round_shr(a * b, 30);
    endfunction

    function automatic t_q16 scale_dt(t_q16 v, logic [15:0] dt);
        t_wide wdt;
        wdt = t_wide'({54'd0, dt});
        return clamp32(round_shr(t_wide'(v) * wdt, 16));
    endfunction

    function automatic void sine_cosine(input t_q16 ang, output t_wide sn, output t_wide cs);
        t_wide r, x, y, dx, dy;
        logic flip;
        r = (t_wide'(ang) * 70'sd16384) % TWO_PI;
        flip = 1'b0;
        x = 70'sd1073741824;
        y = 0;
        if (r < 0) r = r + TWO_PI;
        if (r > PI_Q30) r = r - TWO_PI;
        // fold into the right half plane, which negates both outputs
        if (r > HALF_PI) begin
            r = r - PI_Q30;
            flip = 1'b1;
        end else if (r < -HALF_PI) begin
            r = r + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < (TRIG_STEPS < 30 ? TRIG_STEPS : 30); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x = x - dx;
                y = y + dy;
                r = r - t_wide'(ARCTAN_Q30[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                r = r + t_wide'(ARCTAN_Q30[i]);
            end
        end
        x = q30_mul(x, GAIN_Q30);
        y = q30_mul(y, GAIN_Q30);
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic void rotate_zyx(inout t_q16 v [3], input t_q16 ang [3]);
        t_wide sx, cx, sy, cy, sz, cz, acc;
        t_wide m [3][3];
        t_wide s [3];
        sine_cosine(ang[0], sx, cx);
        sine_cosine(ang[1], sy, cy);
        sine_cosine(ang[2], sz, cz);
        m[0][0] = q30_mul(cy, cz);
        m[0][1] = -q30_mul(cx, sz) + q30_mul(q30_mul(sx, sy), cz);
        m[0][2] = q30_mul(sx, sz) + q30_mul(q30_mul(cx, sy), cz);
        m[1][0] = q30_mul(cy, sz);
        m[1][1] = q30_mul(cx, cz) + q30_mul(q30_mul(sx, sy), sz);
        m[1][2] = -q30_mul(sx, cz) + q30_mul(q30_mul(cx, sy), sz);
        m[2][0] = -sy;
        m[2][1] = q30_mul(sx, cy);
        m[2][2] = q30_mul(cx, cy);
        for (int i = 0; i < 3; i++) s[i] = t_wide'(v[i]);
        for (int r = 0; r < 3; r++) begin
            acc = m[r][0] * s[0] + m[r][1] * s[1] + m[r][2] * s[2];
            v[r] = clamp32(round_shr(acc, 30));
        end
    endfunction

    function automatic logic [11:0][31:0] advance_state(t_q16 accel [3], t_q16 rates [3],
                                                        logic [15:0] dt);
        t_q16 inc [3];
        logic any_set;
        logic [11:0][31:0] snap;
        for (int i = 0; i < 3; i++) begin
            body_rates[i] = rates[i];
            velocity[i] = clamp32(t_wide'(velocity[i]) + t_wide'(scale_dt(accel[i], dt)));
        end
        any_set = 1'b0;
        for (int i = 0; i < 3; i++) begin
            inc[i] = scale_dt(body_rates[i], dt);
            if (inc[i] != 0) any_set = 1'b1;
        end
        if (any_set) rotate_zyx(inc, attitude);
        for (int i = 0; i < 3; i++)
            attitude[i] = clamp32(t_wide'(attitude[i]) + t_wide'(inc[i]));
        // zero attitude leaves the position increment unrotated
        any_set = 1'b0;
        for (int i = 0; i < 3; i++) begin
            inc[i] = scale_dt(velocity[i], dt);
            if (attitude[i] != 0) any_set = 1'b1;
        end
        if (any_set) rotate_zyx(inc, attitude);
        for (int i = 0; i < 3; i++) begin
            position[i] = clamp32(t_wide'(position[i]) + t_wide'(inc[i]));
            snap[i] = position[i];
            snap[3 + i] = attitude[i];
            snap[6 + i] = velocity[i];
            snap[9 + i] = body_rates[i];
        end
        return snap;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        logic [11:0][31:0] want;
        t_q16 accel [3];
        t_q16 rates [3];
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                position[i] = 0;
                velocity[i] = 0;
                attitude[i] = 0;
                body_rates[i] = 0;
            end
            state_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_REGS)
                position[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                accel = '{i_accel_x, i_accel_y, i_accel_z};
                rates = '{i_rate_x, i_rate_y, i_rate_z};
                state_q.push_back(advance_state(accel, rates, i_time_step));
            end
            if (i_out_valid && !i_out_stall) begin
                if (state_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = state_q.pop_front();
                    for (int i = 0; i < 12; i++)
                        if (want[i] !== i_result[i])
                            report_mismatch($sformatf("%s got %h want %h",
                                field_names[i], i_result[i], want[i]));
                end
            end
        end
        o_pending <= state_q.size();
        o_errors <= errors;
    end

endmodule

@@ tb/imu_dead_reckoning_step_core_tb.sv @@
module imu_dead_reckoning_step_core_tb;

    localparam int CFG_START_X = 0;
    localparam int CFG_START_Y = 1;
    localparam int CFG_START_Z = 2;
    localparam int CFG_UNUSED = 3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 240;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_accel_x = '0;
    logic signed [31:0] i_accel_y = '0;
    logic signed [31:0] i_accel_z = '0;
    logic signed [31:0] i_rate_x = '0;
    logic signed [31:0] i_rate_y = '0;
    logic signed [31:0] i_rate_z = '0;
    logic [15:0]        i_time_step = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [11:0][31:0]  result_bus;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    logic               hold_req = 1'b0;
    logic               hold_taken = 1'b0;
    int                 hold_left = 0;
    logic               no_gaps = 1'b0;
    int                 burst_left = 0;

    imu_dead_reckoning_step_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_rate_x(i_rate_x), .i_rate_y(i_rate_y), .i_rate_z(i_rate_z),
        .i_time_step(i_time_step),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pos_x(result_bus[0]), .o_pos_y(result_bus[1]), .o_pos_z(result_bus[2]),
        .o_roll(result_bus[3]), .o_pitch(result_bus[4]), .o_yaw(result_bus[5]),
        .o_vel_x(result_bus[6]), .o_vel_y(result_bus[7]), .o_vel_z(result_bus[8]),
        .o_out_rate_x(result_bus[9]), .o_out_rate_y(result_bus[10]),
        .o_out_rate_z(result_bus[11])
    );

    imu_dead_reckoning_step_checker state_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_rate_x(i_rate_x), .i_rate_y(i_rate_y), .i_rate_z(i_rate_z),
        .i_time_step(i_time_step),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_result(result_bus), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: one long hold-off on request, otherwise a rotating stall density
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            case ((cycles / 700) % 3)
                0: i_out_stall = 1'b0;
                1: i_out_stall = ($urandom_range(0, 99) < 30);
                default: i_out_stall = ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic write_reg(input int idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = 2'(idx);
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_sample(input logic signed [31:0] ax, ay, az, rx, ry, rz,
                               input logic [15:0] dt);
        i_in_valid = 1'b1;
        i_accel_x = ax;
        i_accel_y = ay;
        i_accel_z = az;
        i_rate_x = rx;
        i_rate_y = ry;
        i_rate_z = rz;
        i_time_step = dt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid = 1'b0;
            burst_left = $urandom_range(0, 15);
            if (!no_gaps) repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_random();
        send_sample(pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_step());
    endtask

    task automatic drain();
        if (i_in_valid) i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_START_X, 32'h7FFFFFF0);
        write_reg(CFG_START_Y, 32'h80000010);
        write_reg(CFG_START_Z, 32'h0);
        write_reg(CFG_UNUSED, 32'h12345678);
        @(negedge i_clk);

        // zero time step: only the rates move
        send_sample(32'sh00010000, -32'sh00010000, 32'sh7FFFFFFF,
                    32'sh00008000, 32'sh80000000, 32'sh7FFFFFFF, 16'd0);
        // zero rates with zero attitude: position increment goes straight through
        send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh00050000, 0, 0, 0, 16'hFFFF);
        send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 0, 0, 0, 16'hFFFF);
        // rate increment that rounds to zero
        send_sample(0, 0, 0, 32'sh00000001, -32'sh00000001, 0, 16'd1);
        // ties in the dt rounding
        send_sample(32'sh00008000, -32'sh00008000, 32'sh00000001, 0, 0, 0, 16'd1);
        send_sample(0, 0, 0, 32'sh0001921F, 0, 0, 16'h8000);
        send_sample(0, 0, 0, 0, 32'sh0001921F, 0, 16'h8000);
        send_sample(0, 0, 0, 0, 0, 32'sh0003243F, 16'hFFFF);
        send_sample(0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF);
        send_sample(0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 16'hFFFF);
        send_sample(32'sh00100000, 32'sh00200000, -32'sh00300000,
                    32'sh00020000, -32'sh00010000, 32'sh00030000, 16'd6554);
        send_sample(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh80000000, 32'sh00000000, 32'sh7FFFFFFF, 16'hFFFF);
        for (int i = 0; i < 8; i++) send_random();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_START_X, (p == 0) ? 32'h80000000 : $urandom);
            write_reg(CFG_START_Y, (p == 1) ? 32'h7FFFFFFF : $urandom);
            write_reg(CFG_START_Z, (p == 2) ? 32'h80000000 : $signed($urandom_range(0, 1 << 22)));
            if (p == 3) write_reg(CFG_UNUSED, $urandom);
            @(negedge i_clk);
            no_gaps = (p == 1);
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender waits until everything has come back
                if (p == 4 && i == PHASE_ITEMS / 2) drain();
                send_random();
            end
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
